/* sv/jlsr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// jlsr_pkg: shared constants and helpers
// Grid geometry, sequencer lengths, register map and small arithmetic helpers
// for the square-ring Laplace relaxation unit.
// ----------------------------------------------------------------------------
package jlsr_pkg;

   localparam int GRID_SIDE = 64;
   localparam int IDX_W     = 6;
   localparam int ADDR_W    = 2 * IDX_W;
   localparam int CELLS     = GRID_SIDE * GRID_SIDE;
   localparam int VAL_W     = 32;
   localparam int H_W       = 25;
   localparam int POS_W     = 26;
   localparam int SWP_W     = 16;
   localparam int PROD_W    = IDX_W + H_W;
   localparam int SQ_W      = 2 * PROD_W - 24;
   localparam int PSQ_W     = 2 * POS_W - 24;
   localparam int DIFF_W    = SQ_W + 1;
   localparam int SUM_W     = VAL_W + 2;

   // shift-line taps, newest beat at tap 0
   localparam int CHAIN_LEN    = 2 * GRID_SIDE + 1;
   localparam int TAP_NEXT_ROW = 0;
   localparam int TAP_RIGHT    = GRID_SIDE - 1;
   localparam int TAP_CENTER   = GRID_SIDE;
   localparam int TAP_LEFT     = GRID_SIDE + 1;
   localparam int TAP_PREV_ROW = 2 * GRID_SIDE;

   localparam int CENTER_LAG = GRID_SIDE + 2;
   localparam int SWEEP_LEN  = CELLS + CENTER_LAG + 2;
   localparam int INIT_LEN   = GRID_SIDE * (GRID_SIDE + 1) + 4;
   localparam int CNT_W      = 13;

   localparam int CSR_AW = 4;
   localparam logic [1:0] REG_GRID  = 2'd0;
   localparam logic [1:0] REG_STEP  = 2'd1;
   localparam logic [1:0] REG_SWEEP = 2'd2;

   localparam logic [IDX_W-1:0] GRID_RST  = 6'd30;
   localparam logic [H_W-1:0]   STEP_RST  = 25'd1677722;
   localparam logic [SWP_W-1:0] SWEEP_RST = 16'd1000;

   // floor(x/3) for x < 128 by reciprocal multiply
   function automatic logic [IDX_W-1:0] div3(input logic [IDX_W:0] x);
      logic [IDX_W+6:0] p;
      p = {6'd0, x} * 13'd43;
      return p[IDX_W+6:7];
   endfunction

   // saturate a wide signed difference to 32 bits
   function automatic logic [VAL_W-1:0] sat32(input logic [DIFF_W-1:0] d);
      logic [VAL_W-1:0] r;
      r = d[VAL_W-1:0];
      if (!d[DIFF_W-1] && (|d[DIFF_W-2:VAL_W-1])) r = 32'h7FFF_FFFF;
      else if (d[DIFF_W-1] && !(&d[DIFF_W-2:VAL_W-1])) r = 32'h8000_0000;
      return r;
   endfunction

endpackage
`default_nettype wire

/* sv/jlsr_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// jlsr_cell: one stage of the grid shift line
// Holds one node value and hands it to the next cell every cycle.
// ----------------------------------------------------------------------------
module jlsr_cell
   import jlsr_pkg::*;
(
   input  wire logic             clock,
   input  wire logic [VAL_W-1:0] d_in,
   output logic      [VAL_W-1:0] q_out
);

   logic [VAL_W-1:0] val_ff;

   always_ff @(posedge clock) begin
      val_ff <= d_in;
   end

   assign q_out = val_ff;

endmodule
`default_nettype wire

/* sv/jacobi_laplace_square_ring_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// jacobi_laplace_square_ring_unit: Jacobi relaxation on a square ring
// Builds the grid, runs the programmed number of five-point sweeps and
// answers one query per request.
// ----------------------------------------------------------------------------
// One request at a time. A request builds the grid and then runs sweep_count
// sweeps; its run time depends on sweep_count only, not on grid_intervals:
// every sweep streams all 4096 words of the simple dual-port grid memory through a
// 129-cell shift line at one word per cycle and writes each updated node back
// in place once its last reader has passed. The reset sweep_count is 1000. A new
// request is accepted as soon as the previous result is in the output register.
// ----------------------------------------------------------------------------
module jacobi_laplace_square_ring_unit
   import jlsr_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   // col_index[5:0], row_index[11:6], x_pos[37:12], y_pos[63:38]
   input  wire logic [63:0]       req_tdata,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   // approx_value[31:0], exact_value[63:32], abs_error[94:64], zero[95]
   output logic      [95:0]       rsp_tdata,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [31:0]       csr_pwdata,
   output logic      [31:0]       csr_prdata,
   output logic                   csr_pready
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_INIT, ST_SWEEP, ST_QUERY, ST_READ
   } state_type;

   state_type        state_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [SWP_W-1:0] sweep_ff;
   logic [IDX_W-1:0] irow_ff;
   logic [IDX_W:0]   islot_ff;

   logic [IDX_W-1:0] csr_grid_ff;
   logic [H_W-1:0]   csr_step_ff;
   logic [SWP_W-1:0] csr_sweep_ff;

   logic [IDX_W-1:0] n_ff, lo_ff, hi_ff, col_ff, row_ff;
   logic [POS_W-1:0] xpos_ff, ypos_ff;
   logic [PSQ_W-1:0] xsq_ff, ysq_ff;
   logic [2*POS_W-1:0] xprod, yprod;

   // ------------------------------------------------------------------ csr
   logic csr_wr;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_grid_ff  <= GRID_RST;
         csr_step_ff  <= STEP_RST;
         csr_sweep_ff <= SWEEP_RST;
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            REG_GRID:  csr_grid_ff  <= csr_pwdata[IDX_W-1:0];
            REG_STEP:  csr_step_ff  <= csr_pwdata[H_W-1:0];
            REG_SWEEP: csr_sweep_ff <= csr_pwdata[SWP_W-1:0];
            default:   ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_GRID:  csr_prdata = {26'd0, csr_grid_ff};
         REG_STEP:  csr_prdata = {7'd0, csr_step_ff};
         REG_SWEEP: csr_prdata = {16'd0, csr_sweep_ff};
         default:   csr_prdata = 32'd0;
      endcase
   end

   // --------------------------------------------------------------- memory
   logic [VAL_W-1:0]  grid_mem [CELLS];
   logic [ADDR_W-1:0] rd_addr;
   logic [VAL_W-1:0]  rdata_ff;
   logic              wr_en_ff, wr_en_in;
   logic [ADDR_W-1:0] wr_addr_ff, wr_addr_in;
   logic [VAL_W-1:0]  wr_data_ff, wr_data_in;

   assign rd_addr = (state_ff == ST_SWEEP) ? cnt_ff[ADDR_W-1:0] : {col_ff, row_ff};

   always_ff @(posedge clock) begin
      if (wr_en_ff) grid_mem[wr_addr_ff] <= wr_data_ff;
      rdata_ff <= grid_mem[rd_addr];
   end

   // ----------------------------------------------------------- shift line
   logic [VAL_W-1:0] tap [CHAIN_LEN];

   for (genvar k = 0; k < CHAIN_LEN; k++) begin : g_chain
      if (k == 0) begin : g_head
         jlsr_cell u_cell (.clock(clock), .d_in(rdata_ff), .q_out(tap[k]));
      end else begin : g_body
         jlsr_cell u_cell (.clock(clock), .d_in(tap[k-1]), .q_out(tap[k]));
      end
   end

   // ----------------------------------------------------- init value pipe
   // slot 0 of each row squares i*h, slot s of 1..64 squares j*h for column j = s-1
   logic [IDX_W-1:0]  op_idx;
   logic              s1_vld_ff, s1_row_ff, s2_vld_ff, s2_row_ff;
   logic [IDX_W-1:0]  s1_i_ff, s1_j_ff, s2_i_ff, s2_j_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [SQ_W-1:0]   sq_ff, sqi_ff;
   logic [2*PROD_W-1:0] sq_full;
   logic              init_issue;

   assign init_issue = (state_ff == ST_INIT) && (cnt_ff < CNT_W'(GRID_SIDE*(GRID_SIDE+1)));
   assign op_idx     = (islot_ff == '0) ? irow_ff : IDX_W'(islot_ff - 1'b1);
   assign sq_full    = prod_ff * prod_ff;
   assign xprod      = xpos_ff * xpos_ff;
   assign yprod      = ypos_ff * ypos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= init_issue;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= op_idx * csr_step_ff;
      s1_row_ff <= (islot_ff == '0);
      s1_i_ff   <= irow_ff;
      s1_j_ff   <= op_idx;
      sq_ff     <= sq_full[2*PROD_W-1:24];
      s2_row_ff <= s1_row_ff;
      s2_i_ff   <= s1_i_ff;
      s2_j_ff   <= s1_j_ff;
      if (s2_vld_ff && s2_row_ff) sqi_ff <= sq_ff;
      xsq_ff    <= xprod[2*POS_W-1:24];
      ysq_ff    <= yprod[2*POS_W-1:24];
   end

   logic init_inner, init_fixed;
   assign init_inner = (s2_i_ff >= lo_ff) && (s2_i_ff <= hi_ff) &&
                       (s2_j_ff >= lo_ff) && (s2_j_ff <= hi_ff);
   assign init_fixed = (s2_i_ff == '0) || (s2_i_ff == n_ff) ||
                       (s2_j_ff == '0) || (s2_j_ff == n_ff) ||
                       (init_inner && ((s2_i_ff == lo_ff) || (s2_i_ff == hi_ff) ||
                                       (s2_j_ff == lo_ff) || (s2_j_ff == hi_ff)));

   // --------------------------------------------------------------- stencil
   logic [CNT_W-1:0]  cen;
   logic [IDX_W-1:0]  ci, cj;
   logic              cen_vld, cen_upd, cen_inner;
   logic [SUM_W-1:0]  nsum;

   assign cen       = cnt_ff - CNT_W'(CENTER_LAG);
   assign ci        = cen[ADDR_W-1:IDX_W];
   assign cj        = cen[IDX_W-1:0];
   assign cen_vld   = (state_ff == ST_SWEEP) && (cnt_ff >= CNT_W'(CENTER_LAG)) &&
                      (cnt_ff < CNT_W'(CENTER_LAG + CELLS));
   assign cen_inner = (ci >= lo_ff) && (ci <= hi_ff) && (cj >= lo_ff) && (cj <= hi_ff);
   assign cen_upd   = cen_vld && (ci != '0) && (ci < n_ff) && (cj != '0) &&
                      (cj < n_ff) && !cen_inner;
   assign nsum = {{2{tap[TAP_NEXT_ROW][VAL_W-1]}}, tap[TAP_NEXT_ROW]} +
                 {{2{tap[TAP_PREV_ROW][VAL_W-1]}}, tap[TAP_PREV_ROW]} +
                 {{2{tap[TAP_RIGHT][VAL_W-1]}}, tap[TAP_RIGHT]} +
                 {{2{tap[TAP_LEFT][VAL_W-1]}}, tap[TAP_LEFT]};

   always_comb begin
      wr_en_in   = 1'b0;
      wr_addr_in = {s2_i_ff, s2_j_ff};
      wr_data_in = init_fixed ? sat32({1'b0, sqi_ff} - {1'b0, sq_ff}) : '0;
      if (s2_vld_ff && !s2_row_ff) begin
         wr_en_in = 1'b1;
      end else if (cen_upd) begin
         wr_en_in   = 1'b1;
         wr_addr_in = cen[ADDR_W-1:0];
         wr_data_in = nsum[SUM_W-1:2];   // arithmetic floor of sum/4
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff <= wr_addr_in;
      wr_data_ff <= wr_data_in;
   end

   // ----------------------------------------------------------- result
   logic [VAL_W-1:0] exact;
   logic [VAL_W:0]   diff, adiff;
   logic [30:0]      abs_err;
   logic [95:0]      rsp_data_ff;
   logic             rsp_valid_ff, rsp_load;

   assign exact   = VAL_W'({1'b0, xsq_ff}) - VAL_W'({1'b0, ysq_ff});
   assign diff    = {rdata_ff[VAL_W-1], rdata_ff} - {exact[VAL_W-1], exact};
   assign adiff   = diff[VAL_W] ? (~diff + 1'b1) : diff;
   assign abs_err = (|adiff[VAL_W:VAL_W-1]) ? 31'h7FFF_FFFF : adiff[30:0];
   assign rsp_load = (state_ff == ST_READ) && (!rsp_valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (rsp_load) rsp_data_ff <= {1'b0, abs_err, exact, rdata_ff};
   end

   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign req_tready = (state_ff == ST_IDLE);

   // ------------------------------------------------------------ control
   logic [IDX_W-1:0] req_col, req_row;
   assign req_col = req_tdata[5:0];
   assign req_row = req_tdata[11:6];

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         n_ff    <= csr_grid_ff;
         lo_ff   <= div3({1'b0, csr_grid_ff});
         hi_ff   <= div3({csr_grid_ff, 1'b0});
         col_ff  <= (req_col > csr_grid_ff) ? csr_grid_ff : req_col;
         row_ff  <= (req_row > csr_grid_ff) ? csr_grid_ff : req_row;
         xpos_ff <= req_tdata[37:12];
         ypos_ff <= req_tdata[63:38];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         sweep_ff     <= '0;
         irow_ff      <= '0;
         islot_ff     <= '0;
         wr_en_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_en_ff     <= wr_en_in;
         rsp_valid_ff <= rsp_load | (rsp_valid_ff & ~rsp_tready);
         unique case (state_ff)
            ST_IDLE: begin
               cnt_ff   <= '0;
               irow_ff  <= '0;
               islot_ff <= '0;
               sweep_ff <= '0;
               if (req_tvalid) state_ff <= ST_INIT;
            end
            ST_INIT: begin
               if (init_issue) begin
                  if (islot_ff == (IDX_W+1)'(GRID_SIDE)) begin
                     islot_ff <= '0;
                     irow_ff  <= irow_ff + 1'b1;
                  end else begin
                     islot_ff <= islot_ff + 1'b1;
                  end
               end
               if (cnt_ff == CNT_W'(INIT_LEN - 1)) begin
                  cnt_ff   <= '0;
                  state_ff <= (csr_sweep_ff == '0) ? ST_QUERY : ST_SWEEP;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_SWEEP: begin
               if (cnt_ff == CNT_W'(SWEEP_LEN - 1)) begin
                  cnt_ff   <= '0;
                  sweep_ff <= sweep_ff + 1'b1;
                  if (sweep_ff + 1'b1 == csr_sweep_ff) state_ff <= ST_QUERY;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_QUERY: state_ff <= ST_READ;
            ST_READ: begin
               if (rsp_load) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // --------------------------------------------------------- assertions
   a_write_phase: assert property (@(posedge clock) disable iff (reset)
      wr_en_ff |-> ($past(state_ff) == ST_INIT || $past(state_ff) == ST_SWEEP))
      else $error("grid write outside build or sweep");

   a_sweep_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> (sweep_ff < csr_sweep_ff))
      else $error("sweep count overrun");

   a_query_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_QUERY) |=> (state_ff == ST_READ))
      else $error("query read skipped");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> rsp_valid_ff)
      else $error("pending result lost");

endmodule
`default_nettype wire

/* dv/testbench.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// testbench: square-ring Jacobi relaxation unit
// Drives requests on the req_ stream and programs the grid through the APB
// port. An in-bench relaxation model predicts each response, which is
// compared field by field. The tests cover boundary and clamped queries,
// small and full-size grids, step extremes and randomized settings with
// bursty senders and a stalling receiver.
// ----------------------------------------------------------------------------
module testbench;
   import jlsr_pkg::*;

   localparam longint CYCLE_LIMIT = 40_000_000;
   localparam int     SIDE        = 64;
   localparam logic [CSR_AW-1:0] ADDR_GRID  = 4'd0;
   localparam logic [CSR_AW-1:0] ADDR_STEP  = 4'd4;
   localparam logic [CSR_AW-1:0] ADDR_SWEEP = 4'd8;
   localparam logic [CSR_AW-1:0] ADDR_HOLE  = 4'd12;

   typedef struct packed {
      logic [31:0] approx_value;
      logic [31:0] exact_value;
      logic [30:0] abs_error;
   } answer_t;

   logic              clock;
   logic              reset;
   logic [63:0]       req_tdata;
   logic              req_tvalid;
   logic              req_tready;
   logic [95:0]       rsp_tdata;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [31:0]       csr_pwdata;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   jacobi_laplace_square_ring_unit dut (.*);

   // shadow copy of the registers
   logic [5:0]  grid_n;
   logic [24:0] step_h;
   logic [15:0] sweep_total;

   longint grid_now [SIDE*SIDE];
   longint grid_nxt [SIDE*SIDE];

   answer_t answer_q[$];
   int      error_count;
   int      sent_count;
   int      checked_count;
   int      burst_left;
   longint  cycle_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("jacobi_laplace_square_ring_unit verification failed");
         $finish;
      end
   end

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      error_count++;
      $display("MISMATCH %s: got %h expected %h (response %0d)", what, got, want,
               checked_count);
   endtask

   function automatic longint sq_q24(input longint unsigned v);
      longint unsigned p;
      p = v * v;
      return longint'(p >> 24);
   endfunction

   function automatic longint clip32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic bit in_core(input int i, input int j, input int lo, input int hi);
      return i >= lo && i <= hi && j >= lo && j <= hi;
   endfunction

   // rebuild, relax and read one node, then form the exact value and error
   function automatic answer_t relax_and_query(input logic [5:0] ci, input logic [5:0] ri,
                                               input logic [25:0] xp, input logic [25:0] yp);
      int      n;
      int      lo;
      int      hi;
      int      qi;
      int      qj;
      longint  s;
      longint  approx;
      longint  exact;
      longint  diff;
      answer_t a;
      n  = grid_n;
      lo = n / 3;
      hi = 2 * n / 3;
      for (int i = 0; i <= n; i++)
         for (int j = 0; j <= n; j++) begin
            bit edge_node;
            edge_node = (i == 0 || i == n || j == 0 || j == n) ||
                        (in_core(i, j, lo, hi) && (i == lo || i == hi || j == lo || j == hi));
            grid_now[i*SIDE+j] = edge_node ?
               clip32(sq_q24(longint'(i) * step_h) - sq_q24(longint'(j) * step_h)) : 0;
         end
      for (int k = 0; k < sweep_total; k++) begin
         for (int i = 1; i < n; i++)
            for (int j = 1; j < n; j++) begin
               if (in_core(i, j, lo, hi)) continue;
               s = grid_now[(i-1)*SIDE+j] + grid_now[(i+1)*SIDE+j] +
                   grid_now[i*SIDE+j-1] + grid_now[i*SIDE+j+1];
               grid_nxt[i*SIDE+j] = (s >= 0) ? s / 4 : -((-s + 3) / 4);
            end
         for (int i = 1; i < n; i++)
            for (int j = 1; j < n; j++)
               if (!in_core(i, j, lo, hi)) grid_now[i*SIDE+j] = grid_nxt[i*SIDE+j];
      end
      qi = (ci > n) ? n : ci;
      qj = (ri > n) ? n : ri;
      approx = grid_now[qi*SIDE+qj];
      exact  = clip32(sq_q24(xp) - sq_q24(yp));
      diff   = approx - exact;
      if (diff < 0) diff = -diff;
      if (diff > 64'sd2147483647) diff = 64'sd2147483647;
      a.approx_value = approx[31:0];
      a.exact_value  = exact[31:0];
      a.abs_error    = diff[30:0];
      return a;
   endfunction

   // sender: bursts of random length separated by random gaps
   task automatic send_query(input logic [5:0] ci, input logic [5:0] ri,
                             input logic [25:0] xp, input logic [25:0] yp);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 6);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
      end else begin
         gap = 0;
      end
      burst_left--;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  = {yp, xp, ri, ci};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      answer_q.push_back(relax_and_query(ci, ri, xp, yp));
      sent_count++;
   endtask

   task automatic send_random_query();
      send_query(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                 26'($urandom_range(0, 26'h3FFFFFF)), 26'($urandom_range(0, 26'h3FFFFFF)));
   endtask

   // drop valid and wait for every outstanding answer, then let the unit settle
   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (answer_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_AW-1:0] addr, input logic [31:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = addr;
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      case (addr)
         ADDR_GRID:  grid_n      = value[5:0];
         ADDR_STEP:  step_h      = value[24:0];
         ADDR_SWEEP: sweep_total = value[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic csr_check(input logic [CSR_AW-1:0] addr, input logic [31:0] want);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = addr;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      if (csr_prdata !== want) report("register readback", csr_prdata, want);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic configure(input logic [31:0] n, input logic [31:0] h, input logic [31:0] sw);
      csr_write(ADDR_GRID, n);
      csr_write(ADDR_STEP, h);
      csr_write(ADDR_SWEEP, sw);
   endtask

   // receiver: alternates open windows with choppy windows in which ready drops at random
   always @(negedge clock) begin
      if (cycle_count[6]) rsp_tready <= ($urandom_range(0, 3) != 0);
      else rsp_tready <= 1'b1;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         answer_t got;
         answer_t want;
         got = {rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[94:64]};
         if (answer_q.size() == 0) begin
            report("unexpected response", rsp_tdata[31:0], 32'd0);
         end else begin
            want = answer_q.pop_front();
            if (got.approx_value !== want.approx_value)
               report("approx_value", got.approx_value, want.approx_value);
            if (got.exact_value !== want.exact_value)
               report("exact_value", got.exact_value, want.exact_value);
            if (got.abs_error !== want.abs_error)
               report("abs_error", {1'b0, got.abs_error}, {1'b0, want.abs_error});
         end
         checked_count++;
      end
   end

   // boundary, ring and clamped queries with no relaxation
   task automatic test_boundary_queries();
      configure(30, 1677722, 0);
      send_query(0, 0, 0, 0);
      send_query(30, 0, 26'h3FFFFFF, 0);
      send_query(0, 30, 0, 26'h3FFFFFF);
      send_query(63, 63, 26'h3FFFFFF, 26'h3FFFFFF);
      send_query(10, 15, 26'h2AAAAAA, 26'h1555555);
      send_query(15, 15, 26'h1000000, 26'h0800000);
      send_query(63, 5, 26'h0000001, 26'h3000000);
      drain();
   endtask

   task automatic test_few_sweeps();
      configure(9, 16777216, 1);
      send_query(1, 1, 26'h1000000, 26'h1000000);
      send_query(7, 2, 26'h3000000, 26'h1000000);
      drain();
      csr_write(ADDR_SWEEP, 3);
      send_query(2, 8, 26'h0800000, 26'h2000000);
      send_query(1, 5, 26'h1234567, 26'h0ABCDEF);
      drain();
   endtask

   // grids below the nominal minimum are used as given
   task automatic test_tiny_grids();
      for (int n = 0; n <= 3; n++) begin
         configure(n, 25'h1FFFFFF, 2);
         send_query(1, 1, 26'h3FFFFFF, 26'h0000000);
         send_query(2, 0, 0, 26'h3FFFFFF);
         drain();
      end
   endtask

   // full grid, largest step drives the boundary into saturation
   task automatic test_full_grid();
      configure(63, 25'h1FFFFFF, 1);
      send_query(62, 1, 26'h3FFFFFF, 0);
      send_query(1, 62, 0, 26'h3FFFFFF);
      drain();
      configure(32'hFFFF_FFFF, 1, 2);
      send_query(40, 3, 26'h0000003, 26'h0000002);
      drain();
   endtask

   task automatic test_register_map();
      configure(32'h0000_0005, 32'hFE00_0000 | 25'h0ABCDEF, 16'hFFFF);
      csr_check(ADDR_SWEEP, 32'h0000_FFFF);
      csr_write(ADDR_HOLE, 32'hFFFF_FFFF);
      csr_check(ADDR_GRID, 32'h0000_0005);
      csr_check(ADDR_STEP, 32'h00AB_CDEF);
      csr_write(ADDR_SWEEP, 0);
      csr_check(ADDR_SWEEP, 0);
      send_query(4, 1, 26'h00FFFFF, 26'h0100000);
      drain();
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 10; phase++) begin
         configure($urandom_range(0, 63), $urandom_range(1, 25'h1FFFFFF),
                   ($urandom_range(0, 9) == 0) ? 6 : $urandom_range(0, 2));
         repeat (10) send_random_query();
         drain();
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b1;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      cycle_count = 0;
      error_count = 0;
      sent_count  = 0;
      checked_count = 0;
      burst_left  = 0;
      grid_n      = GRID_RST;
      step_h      = STEP_RST;
      sweep_total = SWEEP_RST;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_boundary_queries();
      test_few_sweeps();
      test_tiny_grids();
      test_full_grid();
      test_register_map();
      test_random_traffic();

      repeat (20) @(posedge clock);
      $display("%0d requests sent, %0d responses checked over %0d cycles", sent_count,
               checked_count, cycle_count);
      $display("grid sizes 0 to 63, step and sweep extremes, clamped and boundary queries");
      if (error_count == 0 && answer_q.size() == 0) begin
         $display("jacobi_laplace_square_ring_unit verification clean");
      end else begin
         $display("%0d errors, %0d responses missing", error_count, answer_q.size());
         $display("jacobi_laplace_square_ring_unit verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

/* sim.f */
sv/jlsr_pkg.sv
sv/jlsr_cell.sv
sv/jacobi_laplace_square_ring_unit.sv
dv/testbench.sv
